// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the tag store RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SACL_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SACL_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SACL_ASSERT(name, clk, rst_n, prop, msg)
`define SACL_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// File: hw/rtl/sacl_pkg.sv
// Shared types and constants of the LRU tag store.
// No dependencies; used by sacl_if, sacl_lookup and the top module.
`default_nettype none
package sacl_pkg;

    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 32;
    localparam int CNT_W     = 32;
    localparam int WAY_OUT_W = 3;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_MAX_WAYS   = 8;
    localparam int DEF_MAX_SETS   = 512;
    localparam int DEF_ADDR_WIDTH = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

    localparam logic [CFG_W-1:0] RST_OFFSET_BITS = 4'd6;
    localparam logic [CFG_W-1:0] RST_INDEX_BITS  = 4'd4;
    localparam logic [CFG_W-1:0] RST_WAYS_IN_USE = 4'd8;

    typedef struct packed {
        logic [CFG_W-1:0] offset_bits;
        logic [CFG_W-1:0] index_bits;
        logic [CFG_W-1:0] ways_in_use;
    } cfg_t;

    typedef struct packed {
        logic hit;
        logic evicted;
    } lk_flags_t;

endpackage
`default_nettype wire

// File: hw/rtl/sacl_if.sv
// Valid/ready channel interfaces for the address input and the lookup result.
// Depends on sacl_pkg for field widths.
`default_nettype none
interface sacl_in_if;
    logic                        valid;
    logic                        ready;
    logic [sacl_pkg::ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface sacl_out_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic [sacl_pkg::WAY_OUT_W-1:0] way_used;
    logic                           evicted;
    logic [sacl_pkg::CNT_W-1:0]     lookup_count;
    logic [sacl_pkg::CNT_W-1:0]     miss_count;

    modport source (output valid, output hit, output way_used, output evicted,
                    output lookup_count, output miss_count, input ready);
    modport sink   (input valid, input hit, input way_used, input evicted,
                    input lookup_count, input miss_count, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sacl_row_ram.sv
// One-write, one-read synchronous RAM holding one cache set per row.
// No package dependencies.
`default_nettype none
module sacl_row_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 288
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/sacl_lookup.sv
// Tag compare, victim choice and recency update for one set row.
// Depends on sacl_pkg (cfg_t, lk_flags_t, TAG_W).
`default_nettype none
module sacl_lookup #(
    parameter int MAX_WAYS = 8
) (
    input  sacl_pkg::cfg_t                    cfg,
    input  logic [sacl_pkg::TAG_W-1:0]        tag,
    input  logic [MAX_WAYS*(1 + ((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)
                            + sacl_pkg::TAG_W)-1:0] row_in,
    output sacl_pkg::lk_flags_t               flags,
    output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] way,
    output logic [MAX_WAYS*(1 + ((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)
                            + sacl_pkg::TAG_W)-1:0] row_out
);

    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TAG_W   = sacl_pkg::TAG_W;
    localparam int ENTRY_W = 1 + WAY_W + TAG_W;

    logic [4:0]          nways;
    logic [WAY_W-1:0]    last_rank;
    logic [MAX_WAYS-1:0] act;
    logic [MAX_WAYS-1:0] vld;
    logic [MAX_WAYS-1:0] match;
    logic [MAX_WAYS-1:0] inval;
    logic [MAX_WAYS-1:0] oldest;
    logic [MAX_WAYS-1:0] age;
    logic [WAY_W-1:0]    rank_a [MAX_WAYS];
    logic [TAG_W-1:0]    tag_a  [MAX_WAYS];
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    inv_way;
    logic [WAY_W-1:0]    lru_way;
    logic [WAY_W-1:0]    old_rank;
    logic                hit;
    logic                found;
    logic                was_valid;

    // zero ways acts as one, too many as the built number
    always_comb
    begin
        if (cfg.ways_in_use == '0)
        begin
            nways = 5'd1;
        end
        else if ({1'b0, cfg.ways_in_use} > 5'(MAX_WAYS))
        begin
            nways = 5'(MAX_WAYS);
        end
        else
        begin
            nways = {1'b0, cfg.ways_in_use};
        end
        last_rank = WAY_W'(nways - 5'd1);
    end

    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            tag_a[i]  = row_in[i*ENTRY_W +: TAG_W];
            rank_a[i] = row_in[i*ENTRY_W + TAG_W +: WAY_W];
            vld[i]    = row_in[i*ENTRY_W + ENTRY_W - 1];
            act[i]    = 5'(i) < nways;
            match[i]  = act[i] & vld[i] & (tag_a[i] == tag);
            inval[i]  = act[i] & ~vld[i];
            // full set: ranks are 0..n-1, so the oldest holds n-1
            oldest[i] = act[i] & vld[i] & (rank_a[i] == last_rank);
        end
    end

    // lowest-numbered way wins in each encoder
    always_comb
    begin
        hit_way = '0;
        inv_way = '0;
        lru_way = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_way = WAY_W'(i);
            end
            if (inval[i])
            begin
                inv_way = WAY_W'(i);
            end
            if (oldest[i])
            begin
                lru_way = WAY_W'(i);
            end
        end
    end

    always_comb
    begin
        hit       = |match;
        found     = |inval;
        was_valid = hit | ~found;
        if (hit)
        begin
            way = hit_way;
        end
        else if (found)
        begin
            way = inv_way;
        end
        else
        begin
            way = lru_way;
        end
        old_rank      = rank_a[way];
        flags.hit     = hit;
        flags.evicted = ~hit & ~found;
    end

    // touched way becomes rank 0; younger valid ways age by one
    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            age[i] = (WAY_W'(i) != way) && vld[i] && act[i]
                     && (!was_valid || (rank_a[i] < old_rank));
            if (WAY_W'(i) == way)
            begin
                row_out[i*ENTRY_W +: ENTRY_W] = {1'b1, {WAY_W{1'b0}}, tag};
            end
            else if (age[i])
            begin
                row_out[i*ENTRY_W +: ENTRY_W] = {vld[i], rank_a[i] + WAY_W'(1), tag_a[i]};
            end
            else
            begin
                row_out[i*ENTRY_W +: ENTRY_W] = {vld[i], rank_a[i], tag_a[i]};
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/set_assoc_cache_lru_tags.sv
// Set-associative cache tag store with true LRU replacement.
// Depends on sacl_pkg, sacl_if, sacl_row_ram, sacl_lookup, assert_macros.svh.
//
// Use: in_ch carries one byte address per transfer; out_ch returns one result
// per address, in order: hit, the way hit or filled, an eviction flag and the
// saturating lookup and miss counts including this access. The config port
// (cfg_we, cfg_index, cfg_data) sets offset_bits, index_bits and ways_in_use;
// write it only while no access is in flight.
// Pipeline: the set row is read from the row RAM on the input transfer edge
// (registered read) into the lookup stage; tag compare, victim choice and the
// recency update run there and write the row back as the result is registered
// into the output register that drives out_ch.valid. Throughput: one address
// per cycle while out_ch.ready keeps results moving; an access to the same set
// taken on the write-back edge gets the written row from a bypass register.
// Reset, and any write to a valid register index, clears both counters and
// starts a clearing pass over all MAX_SETS rows (one row a cycle) that zeroes the
// valid bits; in_ch.ready stays low through it. Config writes are taken always.
// Stall: a result waits in the output register while out_ch.ready is low; one
// further address may sit in the lookup stage behind it, then in_ch.ready drops.
`default_nettype none
`include "assert_macros.svh"
module set_assoc_cache_lru_tags #(
    parameter int MAX_WAYS   = sacl_pkg::DEF_MAX_WAYS,
    parameter int MAX_SETS   = sacl_pkg::DEF_MAX_SETS,
    parameter int ADDR_WIDTH = sacl_pkg::DEF_ADDR_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    sacl_in_if.sink                          in_ch,
    sacl_out_if.source                       out_ch,
    input  logic                             cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sacl_pkg::CFG_W-1:0]       cfg_data
);

    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int TAG_W   = sacl_pkg::TAG_W;
    localparam int CNT_W   = sacl_pkg::CNT_W;
    localparam int ENTRY_W = 1 + WAY_W + TAG_W;
    localparam int ROW_W   = MAX_WAYS * ENTRY_W;
    // largest k with 2^k no more than MAX_SETS
    localparam int IB_MAX  = $clog2(MAX_SETS + 1) - 1;
    localparam logic [sacl_pkg::ADDR_W-1:0] AMASK = (ADDR_WIDTH >= 32) ? '1
        : sacl_pkg::ADDR_W'((64'd1 << ADDR_WIDTH) - 64'd1);
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);

    sacl_pkg::cfg_t      cfg_reg;
    logic                clearing_reg;
    logic [SET_W-1:0]    clr_idx_reg;
    logic                s1_valid_reg;
    logic                fwd_reg;
    logic [SET_W-1:0]    s1_set_reg;
    logic [TAG_W-1:0]    s1_tag_reg;
    logic [ROW_W-1:0]    wr_row_reg;
    logic                out_valid_reg;
    logic                out_hit_reg;
    logic [sacl_pkg::WAY_OUT_W-1:0] out_way_reg;
    logic                out_evicted_reg;
    logic [CNT_W-1:0]    out_lookups_reg;
    logic [CNT_W-1:0]    out_misses_reg;
    logic [CNT_W-1:0]    lookups_reg;
    logic [CNT_W-1:0]    misses_reg;
    logic [CNT_W-1:0]    lookups_next;
    logic [CNT_W-1:0]    misses_next;

    logic                accept;
    logic                advance;
    logic                cfg_take;
    logic [sacl_pkg::ADDR_W-1:0] addr_m;
    logic [3:0]          ib;
    logic [4:0]          tag_shift;
    logic [SET_W-1:0]    in_set;
    logic [TAG_W-1:0]    in_tag;
    logic [ROW_W-1:0]    rd_row;
    logic [ROW_W-1:0]    row_cur;
    logic [ROW_W-1:0]    new_row;
    sacl_pkg::lk_flags_t lk_flags;
    logic [WAY_W-1:0]    lk_way;
    logic                mem_we;
    logic [SET_W-1:0]    mem_waddr;
    logic [ROW_W-1:0]    mem_wdata;

    // handshake
    assign advance      = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !clearing_reg && (!s1_valid_reg || advance);
    assign accept       = in_ch.valid && in_ch.ready;
    assign cfg_take     = cfg_we && ((cfg_index == sacl_pkg::REG_OFFSET_BITS)
                                  || (cfg_index == sacl_pkg::REG_INDEX_BITS)
                                  || (cfg_index == sacl_pkg::REG_WAYS_IN_USE));

    // set index and tag from the incoming address
    always_comb
    begin
        addr_m    = in_ch.address & AMASK;
        ib        = (cfg_reg.index_bits > 4'(IB_MAX)) ? 4'(IB_MAX) : cfg_reg.index_bits;
        tag_shift = {1'b0, cfg_reg.offset_bits} + {1'b0, ib};
        in_set    = SET_W'((addr_m >> cfg_reg.offset_bits)
                           & ((sacl_pkg::ADDR_W'(1) << ib) - sacl_pkg::ADDR_W'(1)));
        in_tag    = TAG_W'(addr_m >> tag_shift);
    end

    sacl_row_ram #(
        .DEPTH (MAX_SETS),
        .WIDTH (ROW_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (in_set),
        .rdata (rd_row)
    );

    // bypass: the row read on the same edge as the previous write is stale
    assign row_cur = fwd_reg ? wr_row_reg : rd_row;

    sacl_lookup #(
        .MAX_WAYS (MAX_WAYS)
    ) u_lookup (
        .cfg     (cfg_reg),
        .tag     (s1_tag_reg),
        .row_in  (row_cur),
        .flags   (lk_flags),
        .way     (lk_way),
        .row_out (new_row)
    );

    // write port: clearing pass, otherwise the row write-back
    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = advance;
            mem_waddr = s1_set_reg;
            mem_wdata = new_row;
        end
    end

    // saturating counters
    always_comb
    begin
        lookups_next = (lookups_reg == '1) ? lookups_reg : lookups_reg + CNT_W'(1);
        if (!lk_flags.hit && misses_reg != '1)
        begin
            misses_next = misses_reg + CNT_W'(1);
        end
        else
        begin
            misses_next = misses_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_bits <= sacl_pkg::RST_OFFSET_BITS;
            cfg_reg.index_bits  <= sacl_pkg::RST_INDEX_BITS;
            cfg_reg.ways_in_use <= sacl_pkg::RST_WAYS_IN_USE;
            clearing_reg        <= 1'b1;
            clr_idx_reg         <= '0;
            s1_valid_reg        <= 1'b0;
            fwd_reg             <= 1'b0;
            out_valid_reg       <= 1'b0;
            lookups_reg         <= '0;
            misses_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sacl_pkg::REG_OFFSET_BITS: cfg_reg.offset_bits <= cfg_data;
                    sacl_pkg::REG_INDEX_BITS:  cfg_reg.index_bits  <= cfg_data;
                    sacl_pkg::REG_WAYS_IN_USE: cfg_reg.ways_in_use <= cfg_data;
                    default: ;
                endcase
            end

            if (cfg_take)
            begin
                clearing_reg <= 1'b1;
                clr_idx_reg  <= '0;
                lookups_reg  <= '0;
                misses_reg   <= '0;
            end
            else
            begin
                if (clearing_reg)
                begin
                    if (clr_idx_reg == LAST_SET)
                    begin
                        clearing_reg <= 1'b0;
                    end
                    else
                    begin
                        clr_idx_reg <= clr_idx_reg + SET_W'(1);
                    end
                end
                if (advance)
                begin
                    lookups_reg <= lookups_next;
                    misses_reg  <= misses_next;
                end
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= advance && (in_set == s1_set_reg);
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_set_reg <= in_set;
            s1_tag_reg <= in_tag;
        end
        if (advance)
        begin
            wr_row_reg      <= new_row;
            out_hit_reg     <= lk_flags.hit;
            out_evicted_reg <= lk_flags.evicted;
            out_way_reg     <= sacl_pkg::WAY_OUT_W'(lk_way);
            out_lookups_reg <= lookups_next;
            out_misses_reg  <= misses_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.hit          = out_hit_reg;
    assign out_ch.way_used     = out_way_reg;
    assign out_ch.evicted      = out_evicted_reg;
    assign out_ch.lookup_count = out_lookups_reg;
    assign out_ch.miss_count   = out_misses_reg;

    `SACL_ASSERT(a_no_accept_clearing, clk, rst_n, clearing_reg |-> !in_ch.ready, "address taken during clearing pass")
    `SACL_ASSERT(a_miss_le_lookup, clk, rst_n, misses_reg <= lookups_reg, "miss count above lookup count")
    `SACL_ASSERT(a_hit_no_evict, clk, rst_n, out_valid_reg && out_hit_reg |-> !out_evicted_reg, "hit reported with eviction")
    `SACL_ASSERT(a_lookup_step, clk, rst_n, advance && !cfg_take |=> (lookups_reg == $past(lookups_reg) + CNT_W'(1)) || ($past(lookups_reg) == '1), "lookup count did not step")

endmodule
`default_nettype wire

// File: sim/tb_set_assoc_cache_lru_tags.sv
// Self-checking testbench for the set-associative LRU tag store.
// Uses sacl_pkg and the sacl_in_if / sacl_out_if channel interfaces from the RTL;
// drives address transfers and checks every lookup result against a built-in model.
module tb_set_assoc_cache_lru_tags;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NWAYS        = sacl_pkg::DEF_MAX_WAYS;
    localparam int NSETS        = sacl_pkg::DEF_MAX_SETS;
    localparam int SET_BITS_MAX = $clog2(NSETS + 1) - 1;   // floor(log2(NSETS))
    localparam int RANK_W       = $clog2(NWAYS);

    // index with no register behind it: must leave the store untouched
    localparam logic [sacl_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 4;      // idle wait before a config write and at the end
    localparam int LONG_HOLD_AT     = 300;    // transfers taken before the long stall
    localparam int LONG_HOLD_CYCLES = 200;

    typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY} rx_mode_t;

    typedef struct packed {
        logic                           hit;
        logic [sacl_pkg::WAY_OUT_W-1:0] way_used;
        logic                           evicted;
        logic [sacl_pkg::CNT_W-1:0]     lookup_count;
        logic [sacl_pkg::CNT_W-1:0]     miss_count;
    } lookup_result_t;

    // ---------------------------------------------------------------------
    // Clock, reset and the block's inputs (all known from time zero)
    // ---------------------------------------------------------------------
    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           in_valid   = 1'b0;
    logic [sacl_pkg::ADDR_W-1:0]    in_address = '0;
    logic                           out_ready  = 1'b0;
    logic                           cfg_we     = 1'b0;
    logic [sacl_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
    logic [sacl_pkg::CFG_W-1:0]     cfg_data   = '0;

    always #1 clk = ~clk;

    sacl_in_if  in_ch ();
    sacl_out_if out_ch ();

    assign in_ch.valid   = in_valid;
    assign in_ch.address = in_address;
    assign out_ch.ready  = out_ready;

    set_assoc_cache_lru_tags u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------------
    // Shadow of the tag store: configuration, per-line state and counters
    // ---------------------------------------------------------------------
    logic [sacl_pkg::CFG_W-1:0] shadow_offset = sacl_pkg::RST_OFFSET_BITS;
    logic [sacl_pkg::CFG_W-1:0] shadow_index  = sacl_pkg::RST_INDEX_BITS;
    logic [sacl_pkg::CFG_W-1:0] shadow_ways   = sacl_pkg::RST_WAYS_IN_USE;

    bit                         line_valid [NSETS][NWAYS];
    logic [sacl_pkg::TAG_W-1:0] line_tag   [NSETS][NWAYS];
    logic [RANK_W-1:0]          line_age   [NSETS][NWAYS];   // 0 = most recently used
    logic [sacl_pkg::CNT_W-1:0] lookups_total = '0;
    logic [sacl_pkg::CNT_W-1:0] misses_total  = '0;

    logic [sacl_pkg::ADDR_W-1:0] pending_addrs [$];     // addresses not yet transferred
    lookup_result_t              expected_results [$];  // predictions awaiting their result

    logic in_fire      = 1'b0;                   // input transfer at the last rising edge
    int   inputs_taken = 0;
    int   results_seen = 0;
    int   hits_seen    = 0;
    int   evicts_seen  = 0;
    int   geometries   = 1;
    int   fail_count   = 0;
    int   cycle_count  = 0;

    function automatic int sets_bits_in_use();
        return (int'(shadow_index) > SET_BITS_MAX) ? SET_BITS_MAX : int'(shadow_index);
    endfunction

    // zero ways behaves as one, anything above the built ways as the maximum
    function automatic int ways_active();
        if (shadow_ways == '0)
            return 1;
        return (int'(shadow_ways) > NWAYS) ? NWAYS : int'(shadow_ways);
    endfunction

    function automatic logic [sacl_pkg::CNT_W-1:0] sat_inc(logic [sacl_pkg::CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Make way w the youngest; valid ways younger than its old age get one older.
    // A way that was not valid counts as older than everything.
    function automatic void touch_way(int s, int nw, int w, bit was_valid);
        int old_age;
        old_age = was_valid ? int'(line_age[s][w]) : NWAYS;
        for (int i = 0; i < nw; i++)
            if (i != w && line_valid[s][i] && int'(line_age[s][i]) < old_age)
                line_age[s][i] = line_age[s][i] + 1'b1;
        line_age[s][w] = '0;
    endfunction

    function automatic lookup_result_t predict_lookup(logic [sacl_pkg::ADDR_W-1:0] addr);
        int                         ib;
        int                         nw;
        int                         s;
        int                         way;
        bit                         hit;
        bit                         found;
        bit                         evicted;
        logic [sacl_pkg::TAG_W-1:0] tag;
        lookup_result_t             r;
        ib      = sets_bits_in_use();
        nw      = ways_active();
        s       = int'((addr >> shadow_offset) & ((32'd1 << ib) - 1));
        tag     = addr >> (int'(shadow_offset) + ib);
        way     = 0;
        hit     = 1'b0;
        found   = 1'b0;
        evicted = 1'b0;

        for (int i = 0; i < nw; i++)
            if (!hit && line_valid[s][i] && line_tag[s][i] == tag)
            begin
                hit = 1'b1;
                way = i;
            end

        if (hit)
            touch_way(s, nw, way, 1'b1);
        else
        begin
            misses_total = sat_inc(misses_total);
            for (int i = 0; i < nw; i++)
                if (!found && !line_valid[s][i])
                begin
                    found = 1'b1;
                    way   = i;
                end
            if (found)
                touch_way(s, nw, way, 1'b0);
            else
            begin
                // set full: the oldest way goes
                for (int i = 1; i < nw; i++)
                    if (line_age[s][i] > line_age[s][way])
                        way = i;
                evicted = 1'b1;
                touch_way(s, nw, way, 1'b1);
            end
            line_valid[s][way] = 1'b1;
            line_tag[s][way]   = tag;
        end
        lookups_total = sat_inc(lookups_total);

        r.hit          = hit;
        r.way_used     = way[sacl_pkg::WAY_OUT_W-1:0];
        r.evicted      = evicted;
        r.lookup_count = lookups_total;
        r.miss_count   = misses_total;
        return r;
    endfunction

    // Mostly addresses that fold onto a few sets with a handful of tags more than the
    // ways in use, so sets fill and the LRU choice is exercised; some fully random ones.
    function automatic logic [sacl_pkg::ADDR_W-1:0] pick_address();
        int          ib;
        int          nsets;
        logic [63:0] set_idx;
        logic [63:0] tag;
        logic [63:0] low;
        logic [63:0] a;
        if ($urandom_range(0, 4) == 0)
            return $urandom();
        ib    = sets_bits_in_use();
        nsets = 1 << ib;
        if ($urandom_range(0, 2) == 0)
            set_idx = $urandom_range(0, nsets - 1);
        else
            set_idx = $urandom_range(0, (nsets > 4) ? 3 : nsets - 1);
        tag = $urandom_range(0, ways_active() + 2);
        low = $urandom();
        a   = (tag << (int'(shadow_offset) + ib)) | (set_idx << shadow_offset)
            | (low & ((64'd1 << shadow_offset) - 1));
        return a[sacl_pkg::ADDR_W-1:0];
    endfunction

    function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t ns: %s mismatch on result %0d, expected %0h, got %0h",
                     $time, fname, results_seen, want, got);
        end
    endfunction

    // ---------------------------------------------------------------------
    // Driver: offers pending addresses in bursts with random gaps.
    // Valid and address are held until the transfer happens.
    // ---------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge clk)
    begin : drv_proc
        bit holding;
        if (in_fire)
            pending_addrs.delete(0);
        holding = in_valid && !in_fire;
        if (!holding)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_addrs.size() == 0)
                in_valid <= 1'b0;
            else
            begin
                in_valid   <= 1'b1;
                in_address <= pending_addrs[0];
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    // a third of bursts run straight into the next one
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: ready follows a pattern that changes mode at random intervals,
    // plus one long hold-off so the block backs up into its input.
    // ---------------------------------------------------------------------
    rx_mode_t rx_mode        = RX_FLOW;
    int       mode_left      = 0;
    int       hold_left      = 0;
    bit       long_hold_done = 1'b0;

    always @(negedge clk)
    begin : rx_proc
        if (!long_hold_done && inputs_taken >= LONG_HOLD_AT)
        begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(16, 96);
            end
            else
                mode_left--;
            case (rx_mode)
                RX_FLOW:  out_ready <= 1'b1;
                RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
                default:  out_ready <= $urandom_range(0, 1);
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: checks each result transfer against the oldest prediction,
    // then predicts for an address transfer on the same edge.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : mon_proc
        lookup_result_t got;
        lookup_result_t want;
        in_fire <= rst_n && (in_ch.valid === 1'b1) && (in_ch.ready === 1'b1);

        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got.hit          = out_ch.hit;
            got.way_used     = out_ch.way_used;
            got.evicted      = out_ch.evicted;
            got.lookup_count = out_ch.lookup_count;
            got.miss_count   = out_ch.miss_count;
            results_seen++;
            if (got.hit === 1'b1)
                hits_seen++;
            if (got.evicted === 1'b1)
                evicts_seen++;
            if (expected_results.size() == 0)
            begin
                fail_count++;
                $display("%0t ns: unexpected result, expected none, got %0h",
                         $time, got);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("hit",          32'(want.hit),      32'(got.hit));
                check_field("way_used",     32'(want.way_used), 32'(got.way_used));
                check_field("evicted",      32'(want.evicted),  32'(got.evicted));
                check_field("lookup_count", want.lookup_count,  got.lookup_count);
                check_field("miss_count",   want.miss_count,    got.miss_count);
            end
        end

        if (rst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        begin
            expected_results.push_back(predict_lookup(in_ch.address));
            inputs_taken++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus sequencing
    // ---------------------------------------------------------------------
    task automatic wait_drained();
        while (pending_addrs.size() != 0 || expected_results.size() != 0 || in_valid)
            @(negedge clk);
    endtask

    task automatic queue_lookups(int n);
        @(posedge clk);
        repeat (n)
            pending_addrs.push_back(pick_address());
    endtask

    // A write to a real register clears the valid bits and both counters; the
    // block then runs its clearing pass, which the handshake simply waits out.
    task automatic write_reg(logic [sacl_pkg::CFG_IDX_W-1:0] idx,
                             logic [sacl_pkg::CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        case (idx)
            sacl_pkg::REG_OFFSET_BITS: shadow_offset = data;
            sacl_pkg::REG_INDEX_BITS:  shadow_index  = data;
            sacl_pkg::REG_WAYS_IN_USE: shadow_ways   = data;
            default: ;
        endcase
        if (idx != REG_NONE)
        begin
            for (int s = 0; s < NSETS; s++)
                for (int w = 0; w < NWAYS; w++)
                    line_valid[s][w] = 1'b0;
            lookups_total = '0;
            misses_total  = '0;
        end
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic program_cache(logic [sacl_pkg::CFG_W-1:0] off,
                                 logic [sacl_pkg::CFG_W-1:0] idx,
                                 logic [sacl_pkg::CFG_W-1:0] ways);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(sacl_pkg::REG_OFFSET_BITS, off);
        write_reg(sacl_pkg::REG_INDEX_BITS, idx);
        write_reg(sacl_pkg::REG_WAYS_IN_USE, ways);
        geometries++;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, reset geometry (64-byte lines, 16 sets, 8 ways, tag from bit 10 up):
        // zero and all-ones addresses, alternating bits, then tags 1 to 8 into set 0,
        // where tag 0 already sits, so tag 8 evicts the oldest; a refresh and another eviction.
        @(posedge clk);
        pending_addrs.push_back(32'h0000_0000);
        pending_addrs.push_back(32'h0000_0000);
        pending_addrs.push_back(32'hFFFF_FFFF);
        pending_addrs.push_back(32'hFFFF_FFFF);
        pending_addrs.push_back(32'hAAAA_AAAA);
        pending_addrs.push_back(32'h5555_5555);
        for (int t = 1; t <= 8; t++)
            pending_addrs.push_back(32'(t) << 10);
        pending_addrs.push_back((32'd1 << 10) | 32'h3F);
        pending_addrs.push_back(32'd9 << 10);
        queue_lookups(150);

        // one set, one way, byte lines: every new tag replaces the line
        program_cache(4'd0, 4'd0, 4'd1);
        queue_lookups(100);

        // widest fields: index clamps to the built sets, ways to the built ways;
        // the long receiver hold-off lands in this phase
        program_cache(4'd15, 4'd15, 4'd15);
        queue_lookups(150);

        // zero ways acts as direct-mapped, largest sets and 4 KiB lines
        program_cache(4'd12, 4'd9, 4'd0);
        queue_lookups(100);

        // odd associativity; the sender stops halfway until everything is back
        program_cache(4'd3, 4'd2, 4'd3);
        queue_lookups(75);
        wait_drained();
        queue_lookups(75);

        // a write to the unused index must leave lines and counters alone
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(REG_NONE, 4'($urandom_range(0, 15)));
        queue_lookups(50);

        // back to the reset values, written explicitly
        program_cache(sacl_pkg::RST_OFFSET_BITS, sacl_pkg::RST_INDEX_BITS,
                      sacl_pkg::RST_WAYS_IN_USE);
        queue_lookups(150);

        wait_drained();
        repeat (SETTLE_CYCLES * 2) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            fail_count++;
            $display("%0t ns: %0d results never arrived", $time, expected_results.size());
        end

        $display("Checked %0d lookups over %0d geometries: %0d hits, %0d evictions.",
                 results_seen, geometries, hits_seen, evicts_seen);
        $display("Included 1-set/1-way, clamped 512-set/8-way, zero-way and stray writes.");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
